// ===== rtl/core/bitmap_font_text_box_layout_assert.svh =====
// Assertion macros shared by the layout block's modules.
`ifndef BITMAP_FONT_TEXT_BOX_LAYOUT_ASSERT_SVH
`define BITMAP_FONT_TEXT_BOX_LAYOUT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BFTL_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define BFTL_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bftl_pkg.sv =====
`default_nettype none
package bftl_pkg;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Pen arithmetic
  localparam int PEN_W = 18;
  localparam logic signed [PEN_W-1:0] PEN_MAX        = 18'sd131071;
  localparam logic signed [PEN_W-1:0] SCREEN_Y_CLAMP = 18'sd191;

  // Special characters and limits
  localparam logic [7:0]  CHAR_NUL     = 8'h00;
  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [15:0] NO_LIMIT     = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // Register reset values
  localparam logic [6:0]  RST_GLYPH_WIDTH  = 7'd8;
  localparam logic [6:0]  RST_GLYPH_HEIGHT = 7'd8;
  localparam logic [15:0] RST_START_X      = 16'd0;
  localparam logic [15:0] RST_START_Y      = 16'd0;
  localparam logic [15:0] RST_LIMIT_X      = 16'd255;
  localparam logic [15:0] RST_LIMIT_Y      = 16'd191;
  localparam logic [15:0] RST_MAX_CHARS    = 16'hFFFF;
  localparam logic [15:0] RST_DEPTH        = 16'd0;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH,
    REG_GLYPH_HEIGHT,
    REG_START_X,
    REG_START_Y,
    REG_LIMIT_X,
    REG_LIMIT_Y,
    REG_MAX_CHARS,
    REG_DEPTH_PRIORITY
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]         glyph_width;
    logic [6:0]         glyph_height;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] limit_x;
    logic signed [15:0] limit_y;
    logic [15:0]        max_chars;
    logic signed [15:0] depth_priority;
  } cfg_t;

  // Classified work for the back end
  typedef struct packed {
    logic        is_done;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  code;
    logic [15:0] count;
  } job_t;

  typedef struct packed {
    logic               quad_valid;
    logic               done_res;
    logic signed [15:0] x_left;
    logic signed [15:0] y_top;
    logic signed [15:0] x_right;
    logic signed [15:0] y_bottom;
    logic [11:0]        u_left;
    logic [9:0]         v_top;
    logic [11:0]        u_right;
    logic [9:0]         v_bottom;
    logic signed [15:0] depth;
    logic [15:0]        char_count;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bftl_front.sv =====
`default_nettype none
module bftl_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bftl_pkg::cfg_t  cfg_i,
  input  wire logic            accept_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            first_i,
  output logic                 job_valid_o,
  output bftl_pkg::job_t       job_o
);

  logic signed [bftl_pkg::PEN_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [bftl_pkg::PEN_W-1:0] pen_y_r, pen_y_nxt;
  logic [15:0]                       count_r, count_nxt;
  logic                              stopped_r, stopped_nxt;

  logic signed [bftl_pkg::PEN_W-1:0] sx_ext, lx_ext, ly_ext, ylim;
  logic signed [bftl_pkg::PEN_W-1:0] px_base, py_base, px_g, py_g, line_y;
  logic signed [bftl_pkg::PEN_W:0]   line_sum;
  logic [15:0]                       cnt_base, cnt_inc;
  logic                              stop_base, limit_hit, wrap;

  // Sign-extend registers to pen width and clamp the Y limit to the screen
  always_comb begin
    sx_ext = {{(bftl_pkg::PEN_W-16){cfg_i.start_x[15]}}, cfg_i.start_x};
    lx_ext = {{(bftl_pkg::PEN_W-16){cfg_i.limit_x[15]}}, cfg_i.limit_x};
    ly_ext = {{(bftl_pkg::PEN_W-16){cfg_i.limit_y[15]}}, cfg_i.limit_y};
    ylim   = (ly_ext > bftl_pkg::SCREEN_Y_CLAMP) ? bftl_pkg::SCREEN_Y_CLAMP : ly_ext;
  end

  // Pen and count as seen by this beat, after an optional restart
  always_comb begin
    if (first_i) begin
      px_base   = sx_ext;
      py_base   = {{(bftl_pkg::PEN_W-16){cfg_i.start_y[15]}}, cfg_i.start_y};
      cnt_base  = '0;
      stop_base = 1'b0;
    end else begin
      px_base   = pen_x_r;
      py_base   = pen_y_r;
      cnt_base  = count_r;
      stop_base = stopped_r;
    end
    line_sum  = $signed({py_base[bftl_pkg::PEN_W-1], py_base})
              + $signed({{(bftl_pkg::PEN_W-6){1'b0}}, cfg_i.glyph_height});
    line_y    = (line_sum > $signed({1'b0, bftl_pkg::PEN_MAX})) ? bftl_pkg::PEN_MAX
                                                             : line_sum[bftl_pkg::PEN_W-1:0];
    cnt_inc   = (cnt_base == bftl_pkg::COUNT_MAX) ? cnt_base : cnt_base + 16'd1;
    limit_hit = (cfg_i.max_chars != bftl_pkg::NO_LIMIT) && (cnt_base >= cfg_i.max_chars);
    wrap      = px_base > lx_ext;
    px_g      = wrap ? sx_ext : px_base;
    py_g      = wrap ? line_y : py_base;
  end

  // Classify the beat and advance the pen
  always_comb begin
    pen_x_nxt   = pen_x_r;
    pen_y_nxt   = pen_y_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    job_valid_o = 1'b0;
    job_o.is_done = 1'b0;
    job_o.x       = px_g[15:0];
    job_o.y       = py_g[15:0];
    job_o.code    = char_i;
    job_o.count   = cnt_inc;
    if (accept_i) begin
      pen_x_nxt   = px_base;
      pen_y_nxt   = py_base;
      count_nxt   = cnt_base;
      stopped_nxt = stop_base;
      if (stop_base) begin
        // drop until the next string starts
      end else if (limit_hit || (char_i == bftl_pkg::CHAR_NUL)) begin
        job_valid_o   = 1'b1;
        job_o.is_done = 1'b1;
        job_o.count   = cnt_base;
        stopped_nxt   = 1'b1;
      end else if (char_i == bftl_pkg::CHAR_NEWLINE) begin
        pen_x_nxt = sx_ext;
        pen_y_nxt = line_y;
        count_nxt = cnt_inc;
      end else if (py_g > ylim) begin
        job_valid_o   = 1'b1;
        job_o.is_done = 1'b1;
        job_o.count   = cnt_base;
        pen_x_nxt     = px_g;
        pen_y_nxt     = py_g;
        stopped_nxt   = 1'b1;
      end else begin
        job_valid_o = 1'b1;
        pen_x_nxt   = px_g + $signed({{(bftl_pkg::PEN_W-7){1'b0}}, cfg_i.glyph_width});
        pen_y_nxt   = py_g;
        count_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= {{(bftl_pkg::PEN_W-16){bftl_pkg::RST_START_X[15]}}, bftl_pkg::RST_START_X};
      pen_y_r   <= {{(bftl_pkg::PEN_W-16){bftl_pkg::RST_START_Y[15]}}, bftl_pkg::RST_START_Y};
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else begin
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bftl_queue.sv =====
`default_nettype none
`include "bitmap_font_text_box_layout_assert.svh"
module bftl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_i,
  input  wire bftl_pkg::job_t  job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output bftl_pkg::job_t       job_o,
  output logic                 empty_o
);

  bftl_pkg::job_t                 entry_r [bftl_pkg::QUEUE_DEPTH];
  logic [bftl_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bftl_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bftl_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == bftl_pkg::QCNT_W'(bftl_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign job_o   = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == bftl_pkg::QPTR_W'(bftl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == bftl_pkg::QPTR_W'(bftl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the job payload
  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= job_i;
    end
  end

  `BFTL_ASSERT_IMP(a_no_push_full, clk, rst_n, push_i, !full_o, "job pushed into full queue")
  `BFTL_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop_i, !empty_o, "job popped from empty queue")
  `BFTL_ASSERT_NXT(a_cnt_grows, clk, rst_n, push_i && !pop_i, cnt_r == $past(cnt_r) + 1'b1, "queue count did not grow on push")

endmodule
`default_nettype wire

// ===== rtl/core/bftl_back.sv =====
`default_nettype none
`include "bitmap_font_text_box_layout_assert.svh"
module bftl_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bftl_pkg::cfg_t  cfg_i,
  input  wire bftl_pkg::job_t  job_i,
  input  wire logic            job_ready_i,
  output logic                 job_take_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output bftl_pkg::res_t       res_o
);

  logic           out_valid_r, out_valid_nxt;
  bftl_pkg::res_t res_r, res_nxt;
  logic [11:0]    u_val;
  logic [9:0]     v_val;

  // Take a job when the output register is free or being drained
  assign job_take_o = job_ready_i && (!out_valid_r || pop_i);
  assign empty_o    = !out_valid_r;
  assign res_o      = res_r;

  // Build the quad and texel rectangle, or a done result
  always_comb begin
    u_val = {7'd0, job_i.code[4:0]} * {5'd0, cfg_i.glyph_width};
    v_val = {7'd0, job_i.code[7:5]} * {3'd0, cfg_i.glyph_height};
    if (job_i.is_done) begin
      res_nxt            = '0;
      res_nxt.done_res   = 1'b1;
      res_nxt.char_count = job_i.count;
    end else begin
      res_nxt.quad_valid = 1'b1;
      res_nxt.done_res   = 1'b0;
      res_nxt.x_left     = job_i.x;
      res_nxt.y_top      = job_i.y;
      res_nxt.x_right    = job_i.x + {9'd0, cfg_i.glyph_width};
      res_nxt.y_bottom   = job_i.y + {9'd0, cfg_i.glyph_height};
      res_nxt.u_left     = u_val;
      res_nxt.v_top      = v_val;
      res_nxt.u_right    = u_val + {5'd0, cfg_i.glyph_width};
      res_nxt.v_bottom   = v_val + {3'd0, cfg_i.glyph_height};
      res_nxt.depth      = cfg_i.depth_priority;
      res_nxt.char_count = job_i.count;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (job_take_o) begin
      out_valid_nxt = 1'b1;
    end else if (pop_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (job_take_o) begin
      res_r <= res_nxt;
    end
  end

  `BFTL_ASSERT_IMP(a_one_kind, clk, rst_n, out_valid_r, res_r.quad_valid ^ res_r.done_res, "result is neither quad nor done")

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_font_text_box_layout.sv =====
// A character's job is written into the job queue, then built into the output register once that is free or drained.
// Throughput: one character per cycle; full rises only when the four-entry job queue
// between the classifier and the quad builder is full, which follows result stalls.
// Newlines and dropped characters give no result.
// Reset: synchronous, active low; empties the queue and the output register, resets the pen,
// and returns all configuration registers to their default values.
`default_nettype none
module bitmap_font_text_box_layout (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // character stream
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        in_character,
  input  wire logic                              in_first_of_string,
  // results
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   out_quad_valid,
  output logic                                   out_done_res,
  output logic signed [15:0]                     out_x_left,
  output logic signed [15:0]                     out_y_top,
  output logic signed [15:0]                     out_x_right,
  output logic signed [15:0]                     out_y_bottom,
  output logic [11:0]                            out_u_left,
  output logic [9:0]                             out_v_top,
  output logic [11:0]                            out_u_right,
  output logic [9:0]                             out_v_bottom,
  output logic signed [15:0]                     out_depth,
  output logic [15:0]                            out_char_count,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bftl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bftl_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bftl_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  bftl_pkg::cfg_t     cfg_r;
  bftl_pkg::reg_idx_t reg_idx;
  logic               cfg_wr, in_acc, job_valid, q_full, q_empty, q_pop;
  bftl_pkg::job_t     job_in, job_head;
  bftl_pkg::res_t     res;

  assign pready  = 1'b1;
  assign reg_idx = bftl_pkg::reg_idx_t'(paddr[bftl_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign full    = q_full;
  assign in_acc  = push && !q_full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width    <= bftl_pkg::RST_GLYPH_WIDTH;
      cfg_r.glyph_height   <= bftl_pkg::RST_GLYPH_HEIGHT;
      cfg_r.start_x        <= bftl_pkg::RST_START_X;
      cfg_r.start_y        <= bftl_pkg::RST_START_Y;
      cfg_r.limit_x        <= bftl_pkg::RST_LIMIT_X;
      cfg_r.limit_y        <= bftl_pkg::RST_LIMIT_Y;
      cfg_r.max_chars      <= bftl_pkg::RST_MAX_CHARS;
      cfg_r.depth_priority <= bftl_pkg::RST_DEPTH;
    end else if (cfg_wr) begin
      case (reg_idx)
        bftl_pkg::REG_GLYPH_WIDTH:    cfg_r.glyph_width    <= pwdata[6:0];
        bftl_pkg::REG_GLYPH_HEIGHT:   cfg_r.glyph_height   <= pwdata[6:0];
        bftl_pkg::REG_START_X:        cfg_r.start_x        <= pwdata[15:0];
        bftl_pkg::REG_START_Y:        cfg_r.start_y        <= pwdata[15:0];
        bftl_pkg::REG_LIMIT_X:        cfg_r.limit_x        <= pwdata[15:0];
        bftl_pkg::REG_LIMIT_Y:        cfg_r.limit_y        <= pwdata[15:0];
        bftl_pkg::REG_MAX_CHARS:      cfg_r.max_chars      <= pwdata[15:0];
        bftl_pkg::REG_DEPTH_PRIORITY: cfg_r.depth_priority <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      bftl_pkg::REG_GLYPH_WIDTH:    prdata = {25'd0, cfg_r.glyph_width};
      bftl_pkg::REG_GLYPH_HEIGHT:   prdata = {25'd0, cfg_r.glyph_height};
      bftl_pkg::REG_START_X:        prdata = {16'd0, cfg_r.start_x};
      bftl_pkg::REG_START_Y:        prdata = {16'd0, cfg_r.start_y};
      bftl_pkg::REG_LIMIT_X:        prdata = {16'd0, cfg_r.limit_x};
      bftl_pkg::REG_LIMIT_Y:        prdata = {16'd0, cfg_r.limit_y};
      bftl_pkg::REG_MAX_CHARS:      prdata = {16'd0, cfg_r.max_chars};
      bftl_pkg::REG_DEPTH_PRIORITY: prdata = {16'd0, cfg_r.depth_priority};
      default:                      prdata = '0;
    endcase
  end

  bftl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .accept_i    (in_acc),
    .char_i      (in_character),
    .first_i     (in_first_of_string),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  bftl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (job_valid),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (job_head),
    .empty_o (q_empty)
  );

  bftl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .job_i       (job_head),
    .job_ready_i (!q_empty),
    .job_take_o  (q_pop),
    .pop_i       (pop && !empty),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign out_quad_valid = res.quad_valid;
  assign out_done_res   = res.done_res;
  assign out_x_left     = res.x_left;
  assign out_y_top      = res.y_top;
  assign out_x_right    = res.x_right;
  assign out_y_bottom   = res.y_bottom;
  assign out_u_left     = res.u_left;
  assign out_v_top      = res.v_top;
  assign out_u_right    = res.u_right;
  assign out_v_bottom   = res.v_bottom;
  assign out_depth      = res.depth;
  assign out_char_count = res.char_count;

endmodule
`default_nettype wire
